// File: rtl/urf_pkg.sv
package urf_pkg;

	// level outputs are always nine bits wide
	localparam int unsigned LEVEL_W = 9;
	localparam int unsigned BYTE_W  = 8;

	typedef enum logic [2:0] {
		REQ_HOST_WR = 3'd0,
		REQ_HOST_RD = 3'd1,
		REQ_LINE_RX = 3'd2,
		REQ_TX_EMPTY = 3'd3,
		REQ_TX_DONE = 3'd4,
		REQ_CLR_TX = 3'd5,
		REQ_CLR_RX = 3'd6
	} req_t;

	// per-item result flags carried from decode to the output register
	typedef struct packed {
		logic push_ok;
		logic host_valid;
		logic line_valid;
		logic send_done;
		logic rx_new;
	} res_flags_t;

endpackage

// File: rtl/uart_tx_rx_ring_fifo_unit.sv
// Dual ring-buffer FIFO for a UART: a transmit ring filled by host writes and
// drained by transmit-empty / transmit-complete events, and a receive ring filled
// by line receives and drained by host reads. Each item returns exactly one
// result. The accepting edge does the decode and the synchronous memory read
// into stage 1, and the output register is loaded from stage 1 when it is
// empty or being taken, so an output stall can hold the result in stage 1.
// The block sustains one item per cycle while in_stall is low; each ring
// memory sees at most one access per item. A full transmit ring rejects a
// host write (push_ok low) and arms the transmit-empty interrupt so draining
// resumes. A receive on a full ring overwrites the oldest slot and the level
// stays at the ring depth. Ring contents are not cleared at reset; only
// indices, counts, interrupt flags and valid bits are.
module uart_tx_rx_ring_fifo_unit #(
	parameter int unsigned TX_DEPTH = 256,
	parameter int unsigned RX_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    req_type,
	input  logic [urf_pkg::BYTE_W-1:0]    data_in,
	input  logic                          burst_last,
	// result output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          push_ok,
	output logic [urf_pkg::BYTE_W-1:0]    host_byte,
	output logic                          host_byte_valid,
	output logic [urf_pkg::BYTE_W-1:0]    line_byte,
	output logic                          line_byte_valid,
	output logic                          send_done,
	output logic                          rx_new,
	output logic [urf_pkg::LEVEL_W-1:0]   tx_level,
	output logic [urf_pkg::LEVEL_W-1:0]   rx_level
);
	import urf_pkg::*;

	localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int unsigned RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);
	localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);
	localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
	localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
	localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);
	localparam logic [RX_CW-1:0] RX_FULL = RX_CW'(RX_DEPTH);

	// ring memories
	logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
	logic [BYTE_W-1:0] rx_mem [RX_DEPTH];

	// ring control state
	logic [TX_AW-1:0] tx_wr_idx_q, tx_rd_idx_q, tx_wr_idx_d, tx_rd_idx_d;
	logic [TX_CW-1:0] tx_cnt_q, tx_cnt_d;
	logic [RX_AW-1:0] rx_wr_idx_q, rx_rd_idx_q, rx_wr_idx_d, rx_rd_idx_d;
	logic [RX_CW-1:0] rx_cnt_q, rx_cnt_d;
	logic             txe_irq_on_q, txe_irq_on_d;
	logic             tc_irq_on_q, tc_irq_on_d;

	// memory strobes for the accepted item
	logic tx_we, tx_re, rx_we, rx_re;

	// decode / memory read stage
	logic                 valid_s1;
	res_flags_t           flags_s1;
	res_flags_t           flags_d;
	logic [LEVEL_W-1:0]   tx_level_s1, rx_level_s1;
	logic [BYTE_W-1:0]    tx_rdata_s1, rx_rdata_s1;

	// output register
	logic out_valid_q;
	logic in_acc, s1_move;

	// stage 1 can move when the output register is empty or being taken
	assign s1_move  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	// request decode against the current ring state
	always_comb begin
		tx_wr_idx_d  = tx_wr_idx_q;
		tx_rd_idx_d  = tx_rd_idx_q;
		tx_cnt_d     = tx_cnt_q;
		rx_wr_idx_d  = rx_wr_idx_q;
		rx_rd_idx_d  = rx_rd_idx_q;
		rx_cnt_d     = rx_cnt_q;
		txe_irq_on_d = txe_irq_on_q;
		tc_irq_on_d  = tc_irq_on_q;
		flags_d      = '0;
		tx_we        = 1'b0;
		tx_re        = 1'b0;
		rx_we        = 1'b0;
		rx_re        = 1'b0;
		case (req_t'(req_type))
			REQ_HOST_WR: begin
				if (tx_cnt_q < TX_FULL) begin
					tx_we            = 1'b1;
					tx_wr_idx_d      = (tx_wr_idx_q == TX_LAST) ? '0 : tx_wr_idx_q + 1'b1;
					tx_cnt_d         = tx_cnt_q + 1'b1;
					flags_d.push_ok  = 1'b1;
					if (burst_last) begin
						txe_irq_on_d = 1'b1;
					end
				end else begin
					// rejected write still arms draining
					txe_irq_on_d = 1'b1;
				end
			end
			REQ_HOST_RD: begin
				if (rx_cnt_q != '0) begin
					rx_re              = 1'b1;
					flags_d.host_valid = 1'b1;
					rx_rd_idx_d        = (rx_rd_idx_q == RX_LAST) ? '0 : rx_rd_idx_q + 1'b1;
					rx_cnt_d           = rx_cnt_q - 1'b1;
				end
			end
			REQ_LINE_RX: begin
				// overwrite on overflow, count saturates at depth
				rx_we          = 1'b1;
				rx_wr_idx_d    = (rx_wr_idx_q == RX_LAST) ? '0 : rx_wr_idx_q + 1'b1;
				flags_d.rx_new = 1'b1;
				if (rx_cnt_q < RX_FULL) begin
					rx_cnt_d = rx_cnt_q + 1'b1;
				end
			end
			REQ_TX_EMPTY: begin
				if (txe_irq_on_q) begin
					if (tx_cnt_q == '0) begin
						txe_irq_on_d = 1'b0;
						tc_irq_on_d  = 1'b1;
					end else begin
						tx_re              = 1'b1;
						flags_d.line_valid = 1'b1;
						tx_rd_idx_d        = (tx_rd_idx_q == TX_LAST) ? '0 : tx_rd_idx_q + 1'b1;
						tx_cnt_d           = tx_cnt_q - 1'b1;
					end
				end
			end
			REQ_TX_DONE: begin
				if (tc_irq_on_q) begin
					if (tx_cnt_q == '0) begin
						tc_irq_on_d       = 1'b0;
						flags_d.send_done = 1'b1;
					end else begin
						tx_re              = 1'b1;
						flags_d.line_valid = 1'b1;
						tx_rd_idx_d        = (tx_rd_idx_q == TX_LAST) ? '0 : tx_rd_idx_q + 1'b1;
						tx_cnt_d           = tx_cnt_q - 1'b1;
					end
				end
			end
			REQ_CLR_TX: begin
				tx_wr_idx_d = '0;
				tx_rd_idx_d = '0;
				tx_cnt_d    = '0;
			end
			REQ_CLR_RX: begin
				rx_wr_idx_d = '0;
				rx_rd_idx_d = '0;
				rx_cnt_d    = '0;
			end
			default: begin
				// unused code leaves the state alone
			end
		endcase
	end

	// ring control registers, updated at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wr_idx_q  <= '0;
			tx_rd_idx_q  <= '0;
			tx_cnt_q     <= '0;
			rx_wr_idx_q  <= '0;
			rx_rd_idx_q  <= '0;
			rx_cnt_q     <= '0;
			txe_irq_on_q <= 1'b0;
			tc_irq_on_q  <= 1'b0;
		end else if (in_acc) begin
			tx_wr_idx_q  <= tx_wr_idx_d;
			tx_rd_idx_q  <= tx_rd_idx_d;
			tx_cnt_q     <= tx_cnt_d;
			rx_wr_idx_q  <= rx_wr_idx_d;
			rx_rd_idx_q  <= rx_rd_idx_d;
			rx_cnt_q     <= rx_cnt_d;
			txe_irq_on_q <= txe_irq_on_d;
			tc_irq_on_q  <= tc_irq_on_d;
		end
	end

	// tx ring memory: one access per item, read data held until the next read.
	// an item touches at most one slot of one ring, and a later read sees the array
	// after the earlier write edge, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (in_acc && tx_we) begin
			tx_mem[tx_wr_idx_q] <= data_in;
		end
		if (in_acc && tx_re) begin
			tx_rdata_s1 <= tx_mem[tx_rd_idx_q];
		end
	end

	// rx ring memory
	always_ff @(posedge clk) begin
		if (in_acc && rx_we) begin
			rx_mem[rx_wr_idx_q] <= data_in;
		end
		if (in_acc && rx_re) begin
			rx_rdata_s1 <= rx_mem[rx_rd_idx_q];
		end
	end

	// stage 1 valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			flags_s1    <= flags_d;
			tx_level_s1 <= LEVEL_W'(tx_cnt_d);
			rx_level_s1 <= LEVEL_W'(rx_cnt_d);
		end
	end

	// output payload, bytes forced to zero when not valid
	always_ff @(posedge clk) begin
		if (s1_move) begin
			push_ok         <= flags_s1.push_ok;
			host_byte_valid <= flags_s1.host_valid;
			host_byte       <= flags_s1.host_valid ? rx_rdata_s1 : '0;
			line_byte_valid <= flags_s1.line_valid;
			line_byte       <= flags_s1.line_valid ? tx_rdata_s1 : '0;
			send_done       <= flags_s1.send_done;
			rx_new          <= flags_s1.rx_new;
			tx_level        <= tx_level_s1;
			rx_level        <= rx_level_s1;
		end
	end

	assign out_valid = out_valid_q;

	// an empty ring always has its indices together
	a_tx_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_cnt_q == '0) |-> (tx_wr_idx_q == tx_rd_idx_q))
		else $error("tx ring empty with indices apart");

	// the receive count never passes the ring depth, even on overrun
	a_rx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_cnt_q <= RX_FULL)
		else $error("rx count beyond depth");

	// a result carries at most one kind of activity
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $countones({push_ok, host_byte_valid, line_byte_valid,
			send_done, rx_new}) <= 1)
		else $error("result carries more than one kind");

	// the transmit count never passes the ring depth
	a_tx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_cnt_q <= TX_FULL)
		else $error("tx count beyond depth");

endmodule
